[rtl/box3_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the 3x3 RGB box filter.
// No dependencies; box3_window, box3_div and the top level refer to it by scoped names.
package box3_pkg;

	localparam int CHAN_W     = 8;
	localparam int PIX_W      = 3 * CHAN_W;
	localparam int SUM_W      = 12;   // nine 8-bit samples plus rounding bias
	localparam int COL_W      = 12;
	localparam int ROW_W      = 16;
	localparam int WCFG_W     = 13;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;

	localparam int MAX_WIDTH_DEF = 4096;
	localparam int WIDTH_LIMIT   = 4096;
	localparam int WIN_SIDE      = 3;
	localparam int WIN_ENTRIES   = WIN_SIDE * (WIN_SIDE - 1);

	localparam logic [WCFG_W-1:0] WIDTH_RST  = 13'd4096;
	localparam logic [ROW_W-1:0]  HEIGHT_RST = 16'hFFFF;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	// floor(x/9) == (x * 3641) >> 15 for every x below 32768
	localparam int                RECIP_W    = 12;
	localparam logic [RECIP_W-1:0] RECIP_M   = 12'd3641;
	localparam int                RECIP_SH   = 15;
	localparam logic [SUM_W-1:0]  ROUND_BIAS = 12'd4;

	typedef logic [PIX_W-1:0] pix_t;

	typedef struct packed {
		logic [SUM_W-1:0] blue;
		logic [SUM_W-1:0] green;
		logic [SUM_W-1:0] red;
	} sums_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
	} coord_t;

endpackage

[rtl/box3_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one read port, registered read.
// No dependencies.
module box3_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/box3_window.sv]
`timescale 1ns / 1ps
// 3x3 window: two stored columns plus the incoming column, nine-sample sums.
// Depends on box3_pkg.
module box3_window (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           shift,
	input  box3_pkg::pix_t top,
	input  box3_pkg::pix_t mid,
	input  box3_pkg::pix_t bot,
	output box3_pkg::sums_t sums
);

	box3_pkg::pix_t  win_q [box3_pkg::WIN_ENTRIES];
	box3_pkg::sums_t sums_s2;
	logic [box3_pkg::SUM_W-1:0] acc [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			acc[k] = box3_pkg::SUM_W'(top[k*box3_pkg::CHAN_W +: box3_pkg::CHAN_W])
			       + box3_pkg::SUM_W'(mid[k*box3_pkg::CHAN_W +: box3_pkg::CHAN_W])
			       + box3_pkg::SUM_W'(bot[k*box3_pkg::CHAN_W +: box3_pkg::CHAN_W]);
			for (int e = 0; e < box3_pkg::WIN_ENTRIES; e++) begin
				acc[k] = acc[k]
				       + box3_pkg::SUM_W'(win_q[e][k*box3_pkg::CHAN_W +: box3_pkg::CHAN_W]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < box3_pkg::WIN_ENTRIES; e++) begin
				win_q[e] <= '0;
			end
		end else if (shift) begin
			// oldest column out, newest column in (top, mid, bottom)
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top;
			win_q[4] <= mid;
			win_q[5] <= bot;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			sums_s2.red   <= acc[0];
			sums_s2.green <= acc[1];
			sums_s2.blue  <= acc[2];
		end
	end

	assign sums = sums_s2;

endmodule

[rtl/box3_div.sv]
`timescale 1ns / 1ps
// Output stage: rounded divide by nine through a reciprocal multiply, result register.
// Depends on box3_pkg.
module box3_div (
	input  logic                            clk,
	input  logic                            load,
	input  box3_pkg::sums_t                 sums,
	input  box3_pkg::coord_t                coord_in,
	output logic [box3_pkg::CHAN_W-1:0]     red,
	output logic [box3_pkg::CHAN_W-1:0]     green,
	output logic [box3_pkg::CHAN_W-1:0]     blue,
	output box3_pkg::coord_t                coord_out
);

	localparam int PROD_W = box3_pkg::SUM_W + box3_pkg::RECIP_W;

	logic [box3_pkg::CHAN_W-1:0] red_q, green_q, blue_q;
	box3_pkg::coord_t            coord_q;

	function automatic logic [box3_pkg::CHAN_W-1:0] div9(input logic [box3_pkg::SUM_W-1:0] s);
		logic [box3_pkg::SUM_W-1:0] x;
		logic [PROD_W-1:0]          p;
		x = s + box3_pkg::ROUND_BIAS;
		p = PROD_W'(x) * PROD_W'(box3_pkg::RECIP_M);
		return p[box3_pkg::RECIP_SH +: box3_pkg::CHAN_W];
	endfunction

	always_ff @(posedge clk) begin
		if (load) begin
			red_q   <= div9(sums.red);
			green_q <= div9(sums.green);
			blue_q  <= div9(sums.blue);
			coord_q <= coord_in;
		end
	end

	assign red       = red_q;
	assign green     = green_q;
	assign blue      = blue_q;
	assign coord_out = coord_q;

endmodule

[rtl/box_filter_3x3_rgb.sv]
`timescale 1ns / 1ps
// 3x3 RGB box filter, top level.
// Depends on box3_pkg, box3_ram, box3_window, box3_div.
//
// Pixels enter in raster order on red_in/green_in/blue_in, one beat per pixel
// (in_valid, in_stall). For each pixel at row >= 2 and column >= 2 one beat
// leaves on the result channel (out_valid, out_stall) carrying the rounded
// mean of the 3x3 neighbourhood centred one row up and one column left, its
// row and column, and frame_last on the final interior pixel of the frame.
// Border pixels give no output beat.
// Throughput: one pixel per clock while the output is not stalled. The pixel
// and its line store RAM read are registered in the first stage, the window
// sum in the second, and the reciprocal multiply in the output register.
// A stalled output holds its beat; the pipeline keeps accepting pixels until
// its two internal stages fill, then in_stall rises.
// Reset: width 4096, height 65535, position at row 0 column 0, window zeroed.
// The line store RAM is not cleared; its first two rows are never used for
// output. Writing either register restarts the frame at row 0 column 0.
// image_width is held to 3..min(4096, MAX_WIDTH), image_height to at least 3.
module box_filter_3x3_rgb #(
	parameter int MAX_WIDTH = box3_pkg::MAX_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [box3_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [box3_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [box3_pkg::CHAN_W-1:0]         red_in,
	input  logic [box3_pkg::CHAN_W-1:0]         green_in,
	input  logic [box3_pkg::CHAN_W-1:0]         blue_in,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [box3_pkg::CHAN_W-1:0]         red_out,
	output logic [box3_pkg::CHAN_W-1:0]         green_out,
	output logic [box3_pkg::CHAN_W-1:0]         blue_out,
	output logic [box3_pkg::ROW_W-1:0]          out_row,
	output logic [box3_pkg::COL_W-1:0]          out_col,
	output logic                                frame_last
);

	localparam int DEPTH = (MAX_WIDTH < box3_pkg::WIDTH_LIMIT) ? MAX_WIDTH
	                                                           : box3_pkg::WIDTH_LIMIT;
	localparam int AW    = $clog2(DEPTH);
	localparam int RAM_W = 2 * box3_pkg::PIX_W;
	localparam int W_W   = box3_pkg::WCFG_W;
	localparam int R_W   = box3_pkg::ROW_W;
	localparam int C_W   = box3_pkg::COL_W;

	// configuration
	logic [W_W-1:0] width_q;
	logic [R_W-1:0] height_q;
	logic [W_W-1:0] eff_w;
	logic [R_W-1:0] eff_h;

	// position of the next pixel
	logic [C_W-1:0] col_q;
	logic [R_W-1:0] row_q;
	logic [W_W-1:0] col_inc;
	logic [R_W:0]   row_inc;

	// pipeline
	logic             accept;
	logic             v_s1, v_s2, out_valid_q;
	logic             mv1, ld_o;
	box3_pkg::pix_t   px_s1;
	logic [C_W-1:0]   col_s1;
	logic             emit_s1;
	box3_pkg::coord_t coord_s1, coord_s2, coord_o;
	box3_pkg::pix_t   mid, top;
	box3_pkg::sums_t  sums;
	logic [RAM_W-1:0] ram_rdata;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr, ram_raddr;

	always_comb begin
		eff_w = width_q;
		if (width_q < W_W'(3)) begin
			eff_w = W_W'(3);
		end else if (width_q > W_W'(DEPTH)) begin
			eff_w = W_W'(DEPTH);
		end
		eff_h = (height_q < R_W'(3)) ? R_W'(3) : height_q;
	end

	assign col_inc = {1'b0, col_q} + W_W'(1);
	assign row_inc = {1'b0, row_q} + (R_W + 1)'(1);

	// handshake
	assign ld_o     = v_s2 && (!out_valid_q || !out_stall);
	assign mv1      = v_s1 && (!v_s2 || ld_o);
	assign in_stall = v_s1 && !mv1;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= box3_pkg::WIDTH_RST;
			height_q <= box3_pkg::HEIGHT_RST;
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				box3_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data[W_W-1:0];
				box3_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data[R_W-1:0];
				default: ;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_inc >= eff_w) begin
				col_q <= '0;
				row_q <= (row_inc >= {1'b0, eff_h}) ? '0 : row_inc[R_W-1:0];
			end else begin
				col_q <= col_inc[C_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (mv1) begin
				v_s1 <= 1'b0;
			end
			if (mv1) begin
				v_s2 <= emit_s1;
			end else if (ld_o) begin
				v_s2 <= 1'b0;
			end
			if (ld_o) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1         <= {blue_in, green_in, red_in};
			col_s1        <= col_q;
			emit_s1       <= (row_q >= R_W'(2)) && (col_q >= C_W'(2));
			coord_s1.row  <= row_q - R_W'(1);
			coord_s1.col  <= col_q - C_W'(1);
			coord_s1.last <= (row_q == eff_h - R_W'(1))
			              && ({1'b0, col_q} == eff_w - W_W'(1));
		end
		if (mv1) begin
			coord_s2 <= coord_s1;
		end
	end

	// line stores share one RAM word: upper half two rows up, lower half one row up
	assign ram_raddr = col_q[AW-1:0];
	assign ram_waddr = col_s1[AW-1:0];
	assign ram_we    = mv1;
	assign mid       = ram_rdata[box3_pkg::PIX_W-1:0];
	assign top       = ram_rdata[RAM_W-1:box3_pkg::PIX_W];

	box3_ram #(
		.WIDTH(RAM_W),
		.DEPTH(DEPTH)
	) u_lines (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata({mid, px_s1}),
		.re   (accept),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	box3_window u_window (
		.clk   (clk),
		.arst_n(arst_n),
		.shift (mv1),
		.top   (top),
		.mid   (mid),
		.bot   (px_s1),
		.sums  (sums)
	);

	box3_div u_div (
		.clk      (clk),
		.load     (ld_o),
		.sums     (sums),
		.coord_in (coord_s2),
		.red      (red_out),
		.green    (green_out),
		.blue     (blue_out),
		.coord_out(coord_o)
	);

	assign out_valid  = out_valid_q;
	assign out_row    = coord_o.row;
	assign out_col    = coord_o.col;
	assign frame_last = coord_o.last;

	// a stall towards the source only while the first stage holds a pixel
	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1)
		else $error("input stalled with empty first stage");

	// a line store entry is never read and written in the same cycle
	a_ram_no_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && accept) |-> (ram_waddr != ram_raddr))
		else $error("line store read and write collide");

	// results only ever name interior centre pixels
	a_interior_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_row != '0) && (out_col != '0))
		else $error("border pixel emitted");

	// the frame closes on the last interior column
	a_last_column: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_last) |-> ({1'b0, out_col} == eff_w - W_W'(2)))
		else $error("frame_last away from the last interior column");

endmodule

[tb/tb_box_filter_3x3_rgb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for box_filter_3x3_rgb; needs box3_pkg and the rtl.
// An in-bench model of the line stores and 3x3 window predicts each output beat.

module tb_box_filter_3x3_rgb;
	import box3_pkg::*;

	localparam int HALF_PERIOD   = 5;
	localparam int STALL_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_PIXELS = 1000;
	localparam int MAX_SHOWN     = 10;
	localparam int WIDTH_CAP     = (MAX_WIDTH_DEF < WIDTH_LIMIT) ? MAX_WIDTH_DEF : WIDTH_LIMIT;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} rgb_t;

	typedef struct {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic              last;
	} mean_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [CHAN_W-1:0]     red_in = '0;
	logic [CHAN_W-1:0]     green_in = '0;
	logic [CHAN_W-1:0]     blue_in = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [CHAN_W-1:0]     red_out;
	logic [CHAN_W-1:0]     green_out;
	logic [CHAN_W-1:0]     blue_out;
	logic [ROW_W-1:0]      out_row;
	logic [COL_W-1:0]      out_col;
	logic                  frame_last;

	box_filter_3x3_rgb u_dut (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid, .in_stall, .red_in, .green_in, .blue_in,
		.out_valid, .out_stall, .red_out, .green_out, .blue_out,
		.out_row, .out_col, .frame_last
	);

	// predictor state
	pix_t              line_above [MAX_WIDTH_DEF];
	pix_t              line_two_above [MAX_WIDTH_DEF];
	pix_t              win_px [WIN_ENTRIES];
	int                pos_col = 0;
	int                pos_row = 0;
	logic [WCFG_W-1:0] width_reg = WIDTH_RST;
	logic [ROW_W-1:0]  height_reg = HEIGHT_RST;

	rgb_t  pixel_q [$];
	mean_t means_q [$];

	logic in_fire = 1'b0;
	int   in_gap = 0;
	int   quiet_in = 0;
	int   hold_left = 0;
	int   open_left = 0;
	bit   pressure_done = 0;
	int   beats_out = 0;
	int   bad_beats = 0;
	int   idle_cycles = 0;

	initial begin
		forever #HALF_PERIOD clk = ~clk;
	end

	function automatic int eff_width(input logic [WCFG_W-1:0] v);
		if (v < 3)
			return 3;
		if (v > WIDTH_CAP)
			return WIDTH_CAP;
		return int'(v);
	endfunction

	function automatic int eff_height(input logic [ROW_W-1:0] v);
		return (v < 3) ? 3 : int'(v);
	endfunction

	function automatic void filter_pixel(input rgb_t p);
		int    w;
		int    h;
		int    s;
		pix_t  px;
		pix_t  mid;
		pix_t  top;
		mean_t m;
		logic [CHAN_W-1:0] avg [3];
		w = eff_width(width_reg);
		h = eff_height(height_reg);
		px = {p.blue, p.green, p.red};
		mid = line_above[pos_col];
		top = line_two_above[pos_col];
		if (pos_row >= 2 && pos_col >= 2) begin
			for (int k = 0; k < 3; k++) begin
				s = int'(px[8*k +: 8]) + int'(mid[8*k +: 8]) + int'(top[8*k +: 8]);
				for (int e = 0; e < WIN_ENTRIES; e++)
					s += int'(win_px[e][8*k +: 8]);
				avg[k] = CHAN_W'((s + 4) / 9);
			end
			m.red = avg[0];
			m.green = avg[1];
			m.blue = avg[2];
			m.row = ROW_W'(pos_row - 1);
			m.col = COL_W'(pos_col - 1);
			m.last = (pos_row == h - 1) && (pos_col == w - 1);
			means_q.push_back(m);
		end
		// oldest column drops out; newest is (row-2, row-1, current)
		win_px[0] = win_px[3];
		win_px[1] = win_px[4];
		win_px[2] = win_px[5];
		win_px[3] = top;
		win_px[4] = mid;
		win_px[5] = px;
		line_two_above[pos_col] = mid;
		line_above[pos_col] = px;
		pos_col++;
		if (pos_col >= w) begin
			pos_col = 0;
			pos_row++;
			if (pos_row >= h)
				pos_row = 0;
		end
	endfunction

	// register writes and pixel beats, seen at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					REG_IMAGE_WIDTH: begin
						width_reg = cfg_data[WCFG_W-1:0];
						pos_col = 0;
						pos_row = 0;
					end
					REG_IMAGE_HEIGHT: begin
						height_reg = cfg_data[ROW_W-1:0];
						pos_col = 0;
						pos_row = 0;
					end
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				filter_pixel(rgb_t'({red_in, green_in, blue_in}));
		end
		in_fire <= arst_n && in_valid && !in_stall;
	end

	// result beats against the oldest prediction
	always @(posedge clk) begin
		mean_t want;
		if (arst_n && out_valid && !out_stall) begin
			beats_out++;
			if (means_q.size() == 0) begin
				bad_beats++;
				if (bad_beats <= MAX_SHOWN)
					$display("%0t: unexpected beat row %0d col %0d", $time, out_row, out_col);
			end else begin
				want = means_q.pop_front();
				if (red_out !== want.red || green_out !== want.green
						|| blue_out !== want.blue || out_row !== want.row
						|| out_col !== want.col || frame_last !== want.last) begin
					bad_beats++;
					if (bad_beats <= MAX_SHOWN)
						$display("%0t: exp rgb %0d %0d %0d r%0d c%0d l%0d, got %0d %0d %0d r%0d c%0d l%0d",
							$time, want.red, want.green, want.blue, want.row, want.col,
							want.last, red_out, green_out, blue_out, out_row, out_col,
							frame_last);
				end
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (quiet_in > 0) begin
			quiet_in--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			quiet_in = $urandom_range(40, 200);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// pixel driver
	always @(negedge clk) begin
		logic next_valid;
		rgb_t nxt;
		next_valid = in_valid;
		if (arst_n) begin
			if (in_valid && in_fire) begin
				next_valid = 1'b0;
				in_gap = pick_gap();
			end
			if (!next_valid) begin
				if (in_gap > 0) begin
					in_gap--;
				end else if (pixel_q.size() > 0) begin
					nxt = pixel_q.pop_front();
					red_in <= nxt.red;
					green_in <= nxt.green;
					blue_in <= nxt.blue;
					next_valid = 1'b1;
				end
			end
		end
		in_valid <= next_valid;
	end

	// receiver back-pressure; one long hold once results are flowing and pixels are queued
	always @(negedge clk) begin
		logic next_stall;
		int   r;
		next_stall = 1'b0;
		if (hold_left > 0) begin
			next_stall = 1'b1;
			hold_left--;
		end else if (open_left > 0) begin
			open_left--;
		end else if (!pressure_done && beats_out >= 100 && pixel_q.size() >= 20) begin
			pressure_done = 1;
			hold_left = 400;
			next_stall = 1'b1;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				next_stall = 1'b0;
			end else if (r < 80) begin
				next_stall = 1'b1;
				hold_left = $urandom_range(0, 2);
			end else if (r < 93) begin
				next_stall = 1'b1;
				hold_left = $urandom_range(3, 11);
			end else if (r < 97) begin
				open_left = $urandom_range(50, 300);
			end else begin
				next_stall = 1'b1;
				hold_left = $urandom_range(30, 80);
			end
		end
		out_stall <= next_stall;
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic add_pixel(input logic [CHAN_W-1:0] r, g, b);
		pixel_q.push_back(rgb_t'({r, g, b}));
	endtask

	function automatic logic [CHAN_W-1:0] sample(input int style);
		case (style)
			1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			2: return CHAN_W'($urandom_range(120, 136));
			3: return CHAN_W'($urandom_range(0, 1) ? $urandom_range(248, 255) : $urandom_range(0, 7));
			default: return CHAN_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic add_pixels(input int n, input int style);
		for (int i = 0; i < n; i++)
			add_pixel(sample(style), sample(style), sample(style));
	endtask

	// quiet point: every pixel taken, every result seen, pipeline settled
	task automatic drain();
		while (pixel_q.size() > 0 || in_valid || means_q.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		int sent;
		int r;
		int n;
		logic [CFG_DATA_W-1:0] w_val;
		logic [CFG_DATA_W-1:0] h_val;
		foreach (line_above[i]) begin
			line_above[i] = '0;
			line_two_above[i] = '0;
		end
		foreach (win_px[i])
			win_px[i] = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// 3x3 frames from clamped settings: saturation, rounding, wrap to next frame
		write_reg(REG_IMAGE_WIDTH, 16'd0);
		write_reg(REG_IMAGE_HEIGHT, 16'd2);
		for (int i = 0; i < 9; i++)
			add_pixel(8'hFF, 8'hFF, 8'hFF);
		for (int i = 0; i < 9; i++) begin
			if (i == 8)
				add_pixel(8'd5, 8'd4, 8'd13);
			else
				add_pixel(8'd0, 8'd0, 8'd0);
		end
		for (int i = 0; i < 9; i++)
			add_pixel(i[0] ? 8'hAA : 8'h55, i[0] ? 8'h55 : 8'hAA, CHAN_W'(i * 31));
		drain();

		sent = 0;
		while (sent < RANDOM_PIXELS) begin
			r = $urandom_range(0, 99);
			if (r < 10)
				w_val = CFG_DATA_W'($urandom_range(0, 2));
			else if (r < 85)
				w_val = CFG_DATA_W'($urandom_range(3, 24));
			else
				w_val = CFG_DATA_W'($urandom_range(25, 64));
			if (w_val > 24)
				h_val = 16'd3;
			else if ($urandom_range(0, 9) == 0)
				h_val = CFG_DATA_W'($urandom_range(0, 2));
			else
				h_val = CFG_DATA_W'($urandom_range(3, 8));
			if ($urandom_range(0, 1)) begin
				write_reg(REG_IMAGE_WIDTH, w_val);
				write_reg(REG_IMAGE_HEIGHT, h_val);
			end else begin
				write_reg(REG_IMAGE_HEIGHT, h_val);
				write_reg(REG_IMAGE_WIDTH, w_val);
			end
			n = eff_width(w_val[WCFG_W-1:0]) * eff_height(h_val);
			if ($urandom_range(0, 3) == 0)
				n = $urandom_range(1, 2 * n);
			else if (w_val <= 24)
				n = n * $urandom_range(1, 2);
			add_pixels(n, $urandom_range(0, 3));
			sent += n;
			drain();
		end

		// tallest frame: only its first rows are walked
		write_reg(REG_IMAGE_WIDTH, 16'd7);
		write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
		add_pixels(60, 0);
		drain();

		// width data with bits above the register: only the low 13 bits land (width 5)
		write_reg(REG_IMAGE_HEIGHT, 16'd3);
		write_reg(REG_IMAGE_WIDTH, 16'hE005);
		add_pixels(30, 0);
		drain();

		if (bad_beats == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
